@@ sv/spfq_pkg.sv @@
package spfq_pkg;

  // Field widths fixed by the item format
  localparam int unsigned OrderW = 16;
  localparam int unsigned UrgW   = 3;
  localparam int unsigned CpxW   = 3;
  localparam int unsigned StatW  = 3;
  localparam int unsigned EntryW = OrderW + CpxW;

  typedef enum logic [0:0] {
    OP_ADD  = 1'b0,
    OP_TAKE = 1'b1
  } op_e;

  typedef enum logic [StatW-1:0] {
    ST_ADDED       = 3'd0,
    ST_TAKEN       = 3'd1,
    ST_EMPTY       = 3'd2,
    ST_BAD_URGENCY = 3'd3,
    ST_FULL        = 3'd4
  } status_e;

  typedef struct packed {
    logic [0:0]        operation;
    logic [OrderW-1:0] order_number;
    logic [UrgW-1:0]   urgency;
    logic [CpxW-1:0]   complexity;
  } in_item_t;

  typedef struct packed {
    logic [StatW-1:0]  status;
    logic [OrderW-1:0] out_order_number;
    logic [UrgW-1:0]   out_urgency;
    logic [CpxW-1:0]   out_complexity;
    logic [2:0]        nonempty_levels;
  } out_item_t;

  // Store access strobes from the level control
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

  // Per-item result info, registered by the top level
  typedef struct packed {
    status_e         status;
    logic [UrgW-1:0] urgency;
    logic [2:0]      nonempty;
  } res_info_t;

endpackage

@@ sv/strict_priority_fifo_queue_top.sv @@
// Strict-priority order queue: one FIFO per urgency level.
// Input channel (in_valid_i/in_ready_o/in_item_i): one transfer is one
// operation, either an add (order number, urgency, complexity) or a take.
// Output channel (out_valid_o/out_ready_i/out_item_o): exactly one result per
// operation, in order. The result carries a status (added, taken, all empty,
// bad urgency, level full), the taken order's fields (zero otherwise) and the
// number of non-empty levels after the operation.
// out_valid_o rises in the cycle after the input transfer. Unless stalled,
// throughput is one operation per clock. Level selection, pointer update and
// the store access all happen at the input transfer edge; the store read
// data register and the result register form the single output stage.
// Stall: while out_valid_o is high and out_ready_i is low, in_ready_o drops
// and the result holds. A new input is taken in the same cycle the result is
// taken, so there is no bubble.
// Reset: all levels empty, head/tail pointers at zero, no result pending.
// The entry store is not cleared; a take only reads slots an add has written.
module strict_priority_fifo_queue_top #(
  parameter int unsigned LEVELS      = 5,
  parameter int unsigned LEVEL_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  spfq_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output spfq_pkg::out_item_t out_item_o
);
  import spfq_pkg::*;

  localparam int unsigned Entries = LEVELS * LEVEL_DEPTH;
  localparam int unsigned AddrW   = $clog2(Entries);

  logic              fire;
  mem_ctl_t          mem_ctl;
  logic [AddrW-1:0]  wr_addr;
  logic [AddrW-1:0]  rd_addr;
  logic [EntryW-1:0] rd_data;
  res_info_t         res_d;
  res_info_t         res_q;
  logic              valid_q;
  logic              taken;

  // output stage frees up in the same cycle its result is transferred
  assign in_ready_o = !valid_q || out_ready_i;
  assign fire       = in_valid_i && in_ready_o;

  spfq_ctrl #(
    .Levels     (LEVELS),
    .LevelDepth (LEVEL_DEPTH),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (in_item_i),
    .mem_o     (mem_ctl),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr),
    .res_o     (res_d)
  );

  spfq_store #(
    .Entries (Entries),
    .AddrW   (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .mem_i     (mem_ctl),
    .wr_addr_i (wr_addr),
    .wr_data_i ({in_item_i.order_number, in_item_i.complexity}),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (fire) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  // store data is only meaningful for a take; zero the order fields otherwise
  assign taken = (res_q.status == ST_TAKEN);

  assign out_valid_o                 = valid_q;
  assign out_item_o.status           = res_q.status;
  assign out_item_o.out_order_number = taken ? rd_data[EntryW-1:CpxW] : '0;
  assign out_item_o.out_urgency      = res_q.urgency;
  assign out_item_o.out_complexity   = taken ? rd_data[CpxW-1:0] : '0;
  assign out_item_o.nonempty_levels  = res_q.nonempty;

endmodule

@@ sv/spfq_store.sv @@
module spfq_store #(
  parameter int unsigned Entries = 80,
  parameter int unsigned AddrW   = 7
) (
  input  logic                       clk_i,
  input  spfq_pkg::mem_ctl_t         mem_i,
  input  logic [AddrW-1:0]           wr_addr_i,
  input  logic [spfq_pkg::EntryW-1:0] wr_data_i,
  input  logic [AddrW-1:0]           rd_addr_i,
  output logic [spfq_pkg::EntryW-1:0] rd_data_o
);
  import spfq_pkg::*;

  logic [EntryW-1:0] mem_q [Entries];
  logic [EntryW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read data held until the next read, so it survives an output stall
  always_ff @(posedge clk_i) begin
    if (mem_i.rd_en) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ sv/spfq_ctrl.sv @@
module spfq_ctrl #(
  parameter int unsigned Levels     = 5,
  parameter int unsigned LevelDepth = 16,
  parameter int unsigned AddrW      = 7
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  spfq_pkg::in_item_t  item_i,
  output spfq_pkg::mem_ctl_t  mem_o,
  output logic [AddrW-1:0]    wr_addr_o,
  output logic [AddrW-1:0]    rd_addr_o,
  output spfq_pkg::res_info_t res_o
);
  import spfq_pkg::*;

  localparam int unsigned LvW = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int unsigned PtrW = $clog2(LevelDepth);
  localparam int unsigned CntW = $clog2(LevelDepth + 1);

  logic [PtrW-1:0] head_q [Levels];
  logic [PtrW-1:0] tail_q [Levels];
  logic [CntW-1:0] cnt_q  [Levels];

  logic            urg_ok;
  logic [3:0]      urg_m1;
  logic [LvW-1:0]  add_lv;
  logic [LvW-1:0]  top_lv;
  logic            any_ne;
  logic            do_wr;
  logic            do_rd;
  status_e         status;
  logic [4:0]      nz_sum;
  logic [4:0]      top_urg;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    next_ptr = (p == PtrW'(LevelDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign urg_ok = (item_i.urgency != '0) && ({2'b00, item_i.urgency} <= 5'(Levels));
  assign urg_m1 = {1'b0, item_i.urgency} - 4'd1;
  assign add_lv = LvW'(urg_m1);

  // priority encode: highest non-empty level wins
  always_comb begin
    any_ne = 1'b0;
    top_lv = '0;
    for (int i = 0; i < Levels; i++) begin
      if (cnt_q[i] != '0) begin
        any_ne = 1'b1;
        top_lv = LvW'(i);
      end
    end
  end

  always_comb begin
    do_wr  = 1'b0;
    do_rd  = 1'b0;
    status = ST_EMPTY;
    if (item_i.operation == OP_ADD) begin
      priority if (!urg_ok) begin
        status = ST_BAD_URGENCY;
      end else if (cnt_q[add_lv] == CntW'(LevelDepth)) begin
        status = ST_FULL;
      end else begin
        status = ST_ADDED;
        do_wr  = 1'b1;
      end
    end else if (any_ne) begin
      status = ST_TAKEN;
      do_rd  = 1'b1;
    end
  end

  // non-empty count after this item
  always_comb begin
    nz_sum = '0;
    for (int i = 0; i < Levels; i++) begin
      if ((do_wr && add_lv == LvW'(i)) ||
          ((cnt_q[i] != '0) && !(do_rd && top_lv == LvW'(i) && cnt_q[i] == CntW'(1)))) begin
        nz_sum = nz_sum + 5'd1;
      end
    end
  end

  assign top_urg = 5'(top_lv) + 5'd1;

  assign mem_o.wr_en = fire_i && do_wr;
  assign mem_o.rd_en = fire_i && do_rd;
  assign wr_addr_o   = AddrW'(32'(add_lv) * LevelDepth + 32'(tail_q[add_lv]));
  assign rd_addr_o   = AddrW'(32'(top_lv) * LevelDepth + 32'(head_q[top_lv]));

  assign res_o.status   = status;
  assign res_o.urgency  = do_rd ? top_urg[2:0] : '0;
  assign res_o.nonempty = nz_sum[2:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Levels; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (fire_i) begin
      if (do_wr) begin
        tail_q[add_lv] <= next_ptr(tail_q[add_lv]);
        cnt_q[add_lv]  <= cnt_q[add_lv] + CntW'(1);
      end
      if (do_rd) begin
        head_q[top_lv] <= next_ptr(head_q[top_lv]);
        cnt_q[top_lv]  <= cnt_q[top_lv] - CntW'(1);
      end
    end
  end

endmodule

@@ sv/spfq_checker.sv @@
module spfq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input spfq_pkg::out_item_t out_item_o
);
  import spfq_pkg::*;

  // held result stays put under a stall
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // input only back-pressured by a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // a transfer always yields a result next cycle
  a_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("missing result");

  // order fields zero unless taken, and a take names a real level
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status == ST_TAKEN) ? (out_item_o.out_urgency != '0) :
      (out_item_o.out_order_number == '0 && out_item_o.out_urgency == '0 &&
       out_item_o.out_complexity == '0))
    else $error("bad order fields");

  // empty take means every level is empty
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == ST_EMPTY |-> out_item_o.nonempty_levels == '0)
    else $error("empty status with non-empty levels");

endmodule

bind strict_priority_fifo_queue_top spfq_checker u_spfq_checker (.*);

@@ sim/tb_strict_priority_fifo_queue_top.sv @@
module tb_strict_priority_fifo_queue_top;
  import spfq_pkg::*;

  localparam int unsigned LEVELS      = 5;
  localparam int unsigned LEVEL_DEPTH = 16;
  localparam int unsigned PtrW        = $clog2(LEVEL_DEPTH);
  // Spare cycles at the end catch stray results
  localparam int unsigned TailCycles  = 8;

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  strict_priority_fifo_queue_top #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit well beyond the slowest legal run; hitting it reports failure.
  initial begin
    #2_000_000;
    $display("** strict_priority_fifo_queue_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor: per-level FIFOs with their own pointers and fill counts
  // ---------------------------------------------------------------------------
  logic [EntryW-1:0] lvl_store [LEVELS][LEVEL_DEPTH];
  bit   [PtrW-1:0]   lvl_head  [LEVELS];
  bit   [PtrW-1:0]   lvl_tail  [LEVELS];
  bit   [PtrW:0]     lvl_count [LEVELS];

  out_item_t pending_results[$];   // expected results, oldest first

  int unsigned err_count   = 0;
  int unsigned n_transfers = 0;
  int unsigned n_taken     = 0;
  int unsigned n_full      = 0;
  int unsigned n_bad       = 0;
  int unsigned n_empty     = 0;

  bit no_idle = 1'b0;   // stretches with both sides running flat out

  function automatic bit [PtrW-1:0] next_slot(input bit [PtrW-1:0] p);
    return (p == PtrW'(LEVEL_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Applies one operation to the predictor and returns the result it causes
  function automatic out_item_t queue_model(input in_item_t op_item);
    out_item_t   res;
    int unsigned lv;
    bit          hit;
    res = '0;
    hit = 1'b0;
    if (op_item.operation == OP_ADD) begin
      if (op_item.urgency < 1 || op_item.urgency > LEVELS) begin
        res.status = ST_BAD_URGENCY;
      end else begin
        lv = op_item.urgency - 1;
        if (lvl_count[lv] >= LEVEL_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          lvl_store[lv][lvl_tail[lv]] = {op_item.order_number, op_item.complexity};
          lvl_tail[lv]  = next_slot(lvl_tail[lv]);
          lvl_count[lv] = lvl_count[lv] + 1'b1;
          res.status    = ST_ADDED;
        end
      end
    end else begin
      // highest urgency level wins
      res.status = ST_EMPTY;
      for (int k = LEVELS; k > 0; k--) begin
        if (!hit && lvl_count[k-1] != 0) begin
          {res.out_order_number, res.out_complexity} = lvl_store[k-1][lvl_head[k-1]];
          res.out_urgency = UrgW'(k);
          lvl_head[k-1]   = next_slot(lvl_head[k-1]);
          lvl_count[k-1]  = lvl_count[k-1] - 1'b1;
          res.status      = ST_TAKEN;
          hit             = 1'b1;
        end
      end
    end
    for (int i = 0; i < LEVELS; i++) begin
      if (lvl_count[i] != 0) res.nonempty_levels = res.nonempty_levels + 1'b1;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------
  function automatic in_item_t mk_add(input logic [OrderW-1:0] num,
                                      input logic [UrgW-1:0] urg,
                                      input logic [CpxW-1:0] cpx);
    in_item_t it;
    it.operation    = OP_ADD;
    it.order_number = num;
    it.urgency      = urg;
    it.complexity   = cpx;
    return it;
  endfunction

  // Take with junk in the ignored fields
  function automatic in_item_t mk_take();
    in_item_t it;
    it.operation    = OP_TAKE;
    it.order_number = OrderW'($urandom);
    it.urgency      = UrgW'($urandom);
    it.complexity   = CpxW'($urandom);
    return it;
  endfunction

  // add_pct: share of adds; bad_pct: share of adds with out-of-range urgency;
  // legal urgencies are drawn from urg_lo..urg_hi
  function automatic in_item_t rand_item(input int unsigned add_pct,
                                         input int unsigned bad_pct,
                                         input int unsigned urg_lo,
                                         input int unsigned urg_hi);
    logic [UrgW-1:0] urg;
    if ($urandom_range(99, 0) >= add_pct) return mk_take();
    if ($urandom_range(99, 0) < bad_pct) begin
      case ($urandom_range(2, 0))
        0:       urg = '0;
        1:       urg = UrgW'(LEVELS + 1);
        default: urg = '1;
      endcase
    end else begin
      urg = UrgW'($urandom_range(urg_hi, urg_lo));
    end
    return mk_add(OrderW'($urandom), urg, CpxW'($urandom));
  endfunction

  function automatic int unsigned pick_wait();
    return no_idle ? 0 : $urandom_range(8, 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: one transfer per call; valid is left high afterwards so that
  // back-to-back items never see valid dropped and raised in one step
  // ---------------------------------------------------------------------------
  task automatic send_op(input in_item_t op_item);
    int unsigned gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= op_item;
    @(posedge clk_i);
    while (in_ready_o !== 1'b1) @(posedge clk_i);
    // transfer happened at this edge
    pending_results.push_back(queue_model(op_item));
  endtask

  // Hold off the sender until every expected result has been seen
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random back-pressure, and each transfer checked against the
  // oldest expectation
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input int unsigned want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endtask

  initial begin : result_monitor
    out_item_t   want;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = pick_wait();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (out_valid_o !== 1'b1) @(posedge clk_i);
      n_transfers++;
      if (pending_results.size() == 0) begin
        $error("result with no operation outstanding: %h", out_item_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",           want.status,           out_item_o.status);
        check_field("out_order_number", want.out_order_number, out_item_o.out_order_number);
        check_field("out_urgency",      want.out_urgency,      out_item_o.out_urgency);
        check_field("out_complexity",   want.out_complexity,   out_item_o.out_complexity);
        check_field("nonempty_levels",  want.nonempty_levels,  out_item_o.nonempty_levels);
        case (want.status)
          ST_TAKEN:       n_taken++;
          ST_FULL:        n_full++;
          ST_BAD_URGENCY: n_bad++;
          ST_EMPTY:       n_empty++;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty takes, rejected urgencies, field extremes, priority order
  task automatic test_directed();
    send_op(mk_take());
    send_op(mk_add(16'h1111, 3'd0, 3'd3));
    send_op(mk_add(16'h2222, UrgW'(LEVELS + 1), 3'd4));
    send_op(mk_add(16'h3333, 3'd7, 3'd5));
    send_op(mk_take());
    send_op(mk_add(16'h0000, 3'd1, 3'd0));
    send_op(mk_add(16'hFFFF, UrgW'(LEVELS), 3'd7));
    send_op(mk_add(16'h1234, 3'd3, 3'd5));
    send_op(mk_add(16'hA5A5, 3'd2, 3'd2));
    send_op(mk_add(16'h5A5A, 3'd4, 3'd1));
    send_op(mk_add(16'h0001, UrgW'(LEVELS), 3'd0));
    send_op(mk_add(16'hFFFE, 3'd1, 3'd7));
    // drains highest level first, FIFO order within a level
    repeat (7) send_op(mk_take());
    send_op(mk_take());
  endtask

  // Mixed traffic over all levels with occasional bursts
  task automatic test_random_mix();
    for (int i = 0; i < 500; i++) begin
      if (i % 100 == 0) no_idle = ($urandom_range(9, 0) < 3);
      send_op(rand_item(55, 10, 1, LEVELS));
    end
    no_idle = 1'b0;
  endtask

  // Add-heavy rounds push levels to full and wrap the pointers, then
  // take-heavy rounds empty them again
  task automatic test_fill_overflow();
    int unsigned hi;
    for (int r = 0; r < 4; r++) begin
      hi = (r % 2 == 0) ? 2 : LEVELS;
      repeat (60) send_op(rand_item(92, 3, 1, hi));
      if (r == 1) drain_results();
      repeat (40) send_op(rand_item(12, 5, 1, LEVELS));
    end
  endtask

  // No idling on either side: full-rate transfers and stall-free pipeline
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (450) send_op(rand_item(50, 8, 1, LEVELS));
    no_idle = 1'b0;
  endtask

  initial begin : stimulus
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    drain_results();
    test_random_mix();
    drain_results();
    test_fill_overflow();
    drain_results();
    test_back_to_back();
    drain_results();

    repeat (TailCycles) @(posedge clk_i);

    $display("Checked %0d results: %0d taken, %0d empty takes, %0d full-level drops,",
             n_transfers, n_taken, n_empty, n_full);
    $display("%0d bad-urgency rejects, over idle, stalled and full-rate traffic.", n_bad);
    if (err_count == 0) begin
      $display("** strict_priority_fifo_queue_top: PASSED **");
    end else begin
      $display("** strict_priority_fifo_queue_top: FAILED **");
    end
    $finish;
  end

endmodule
